// ===== sv/pdfte_pkg.sv =====
// ----------------------------------------------------------------------------
// pdfte_pkg: shared definitions for the content stream text extractor
// Window geometry, character codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pdfte_pkg;

   // window of recent stream bytes, newest in the highest slot
   localparam int HIST_LEN = 15;
   localparam int IDX_W    = $clog2(HIST_LEN);
   localparam int PTR_W    = $clog2(HIST_LEN + 1);

   // number scans end at these slots
   localparam logic [PTR_W-1:0] SLOT_TD   = PTR_W'(HIST_LEN - 5);
   localparam logic [PTR_W-1:0] SLOT_OPEN = PTR_W'(HIST_LEN - 1);

   // result buffer: at most three beats per input byte
   localparam int OUT_DEPTH = 3;
   localparam int OIDX_W    = $clog2(OUT_DEPTH);
   localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

   // integer part of a number, saturating
   localparam int              ACC_W        = 16;
   localparam int              MUL_W        = ACC_W + 4;
   localparam logic [ACC_W-1:0] NUM_SAT     = '1;
   localparam logic [ACC_W-1:0] NUM_ONE     = ACC_W'(1);
   localparam logic [ACC_W-1:0] NUM_TAB_MIN = ACC_W'(1000);
   localparam logic [ACC_W-1:0] NUM_SP_MIN  = ACC_W'(100);

   // character codes
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_TILDE = 8'h7e;
   localparam logic [7:0] CH_HI    = 8'h80;
   localparam logic [7:0] CH_FF    = 8'hff;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // take a stream byte, restart stream if flagged
      logic scan_start;  // begin a number scan
      logic scan_open;   // scan kind: 1 for parenthesis, 0 for TD
      logic back_step;   // move scan pointer one slot older
      logic parse_init;  // start forward parse after the stop slot
      logic parse_step;  // consume one slot of the number
      logic take_num;    // turn parsed number into layout beats
      logic finish;      // update flags, queue text, shift window
      logic emit_step;   // one result beat taken
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic td_hit;
      logic open_hit;
      logic at_zero;
      logic cur_space;
      logic cur_numch;
      logic parse_done;
      logic scan_is_td;
      logic will_emit;
      logic emit_last;
   } dp_stat_type;

endpackage

// ===== sv/pdf_content_text_extractor.sv =====
// ----------------------------------------------------------------------------
// pdf_content_text_extractor: text extraction from an inflated content stream
// A byte with no number scan is accepted in the idle state, then decided; its
// result beats are then emitted in order as the receiver takes them.
// A TD or opening parenthesis adds a number scan that walks the 15-slot window
// one slot per cycle; at most two scans per byte.
// One byte is in flight at a time. Synchronous active-high reset clears the
// flags and fills the window with spaces; the next byte is taken right after.
// ----------------------------------------------------------------------------
module pdf_content_text_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] first_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // last_of_run
);

   pdfte_pkg::dp_cmd_type  cmd;
   pdfte_pkg::dp_stat_type stat;

   pdfte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pdfte_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .in_byte  (req_tdata),
      .in_first (req_tuser),
      .out_byte (rsp_tdata),
      .out_last (rsp_tlast)
   );

   // one byte at a time: never take input while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while results pending");

   // a run of results is delivered without gaps
   a_run_contig: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("result run broken before last beat");

   // the cycle after a beat is accepted is spent deciding, not emitting
   a_decide_gap: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!rsp_tvalid && !req_tready))
      else $error("no decide cycle after accepting a byte");

endmodule

// ===== sv/pdfte_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdfte_ctrl: sequencing state machine of the text extractor
// Steps each byte through token decision, number scans, finish and emission.
// ----------------------------------------------------------------------------
module pdfte_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  pdfte_pkg::dp_stat_type stat,
   output pdfte_pkg::dp_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECIDE  = 3'd1;
   localparam logic [2:0] ST_SKIP_SP = 3'd2;
   localparam logic [2:0] ST_SKIP_NM = 3'd3;
   localparam logic [2:0] ST_PARSE   = 3'd4;
   localparam logic [2:0] ST_FINISH  = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (stat.td_hit) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SKIP_SP;
            end else if (stat.open_hit) begin
               cmd.scan_start = 1'b1;
               cmd.scan_open  = 1'b1;
               state_in       = ST_SKIP_SP;
            end else begin
               cmd.finish = 1'b1;
               state_in   = stat.will_emit ? ST_EMIT : ST_IDLE;
            end
         end
         // walk back over trailing spaces
         ST_SKIP_SP: begin
            if (!stat.at_zero && stat.cur_space) begin
               cmd.back_step = 1'b1;
            end else begin
               state_in = ST_SKIP_NM;
            end
         end
         // walk back over digits and dots
         ST_SKIP_NM: begin
            if (!stat.at_zero && stat.cur_numch) begin
               cmd.back_step = 1'b1;
            end else begin
               cmd.parse_init = 1'b1;
               state_in       = ST_PARSE;
            end
         end
         ST_PARSE: begin
            if (stat.parse_done) begin
               cmd.take_num = 1'b1;
               // TD number done; a parenthesis number may follow
               if (stat.scan_is_td && stat.open_hit) begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_open  = 1'b1;
                  state_in       = ST_SKIP_SP;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               cmd.parse_step = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = stat.will_emit ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.emit_step = 1'b1;
               if (stat.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/pdfte_dp.sv =====
// ----------------------------------------------------------------------------
// pdfte_dp: window, flags, number scanner and result buffer
// Holds the byte window and text state, parses numbers one slot per cycle
// and queues the result beats of the current byte.
// ----------------------------------------------------------------------------
module pdfte_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  pdfte_pkg::dp_cmd_type  cmd,
   output pdfte_pkg::dp_stat_type stat,
   input  logic [7:0]            in_byte,
   input  logic                  in_first,
   output logic [7:0]            out_byte,
   output logic                  out_last
);

   logic [7:0] hist_ff [pdfte_pkg::HIST_LEN];
   logic       tobj_ff;
   logic       str_ff;
   logic       esc_ff;
   logic [7:0] char_ff;

   logic [pdfte_pkg::PTR_W-1:0] ptr_ff;
   logic [pdfte_pkg::PTR_W-1:0] last_ff;
   logic                        kind_open_ff;
   logic [pdfte_pkg::ACC_W-1:0] acc_ff;
   logic [pdfte_pkg::ACC_W-1:0] acc_in;
   logic                        dot_ff;
   logic                        frac_ff;
   logic                        digs_ff;

   logic [7:0]                   buf_ff [pdfte_pkg::OUT_DEPTH];
   logic [pdfte_pkg::CNT_W-1:0]  cnt_ff;
   logic [pdfte_pkg::CNT_W-1:0]  cnt_in;
   logic [pdfte_pkg::OIDX_W-1:0] idx_ff;

   logic [7:0] w1, w2, w3, w4;
   logic       td_tok, et_tok, bt_new;
   logic       td_hit, et_hit, open_hit;
   logic [7:0] cur;
   logic       cur_digit, cur_dot, past_end, parse_done;
   logic [pdfte_pkg::MUL_W-1:0] acc_x10;

   logic [1:0] num_n, fin_n, push_n;
   logic [7:0] num_b0, num_b1, fin_b0, fin_b1, push_b0, push_b1;
   logic       tobj_mid, str_in, esc_in, printable;

   function automatic logic is_ws(input logic [7:0] b);
      is_ws = (b == pdfte_pkg::CH_SP) || (b == pdfte_pkg::CH_CR) ||
              (b == pdfte_pkg::CH_LF);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      is_digit = (b >= pdfte_pkg::CH_ZERO) && (b <= pdfte_pkg::CH_NINE);
   endfunction

   // token detection on the four newest slots
   assign w1 = hist_ff[pdfte_pkg::HIST_LEN-1];
   assign w2 = hist_ff[pdfte_pkg::HIST_LEN-2];
   assign w3 = hist_ff[pdfte_pkg::HIST_LEN-3];
   assign w4 = hist_ff[pdfte_pkg::HIST_LEN-4];

   assign td_tok = (w3 == pdfte_pkg::CH_T) && (w2 == pdfte_pkg::CH_D) &&
                   is_ws(w1) && is_ws(w4);
   assign et_tok = (w3 == pdfte_pkg::CH_E) && (w2 == pdfte_pkg::CH_T) &&
                   is_ws(w1) && is_ws(w4);
   // BT as seen after the current byte is shifted in
   assign bt_new = (w2 == pdfte_pkg::CH_B) && (w1 == pdfte_pkg::CH_T) &&
                   is_ws(char_ff) && is_ws(w3);

   assign td_hit   = tobj_ff && !str_ff && td_tok;
   assign et_hit   = tobj_ff && !str_ff && et_tok;
   assign open_hit = tobj_ff && !et_hit && (char_ff == pdfte_pkg::CH_LPAR) &&
                     !str_ff && !esc_ff;

   // slot under the scan pointer
   always_comb begin
      cur = pdfte_pkg::CH_SP;
      if (ptr_ff < pdfte_pkg::PTR_W'(pdfte_pkg::HIST_LEN)) begin
         cur = hist_ff[ptr_ff[pdfte_pkg::IDX_W-1:0]];
      end
   end

   assign cur_digit  = is_digit(cur);
   assign cur_dot    = (cur == pdfte_pkg::CH_DOT);
   assign past_end   = (ptr_ff > last_ff);
   assign parse_done = past_end || (dot_ff ? !cur_digit : !(cur_digit || cur_dot));

   // integer part: acc * 10 + digit, saturating
   assign acc_x10 = (pdfte_pkg::MUL_W'(acc_ff) << 3) + (pdfte_pkg::MUL_W'(acc_ff) << 1) +
                    pdfte_pkg::MUL_W'(cur[3:0]);
   assign acc_in  = (acc_x10 > pdfte_pkg::MUL_W'(pdfte_pkg::NUM_SAT)) ?
                    pdfte_pkg::NUM_SAT : acc_x10[pdfte_pkg::ACC_W-1:0];

   // layout beats chosen by the parsed number
   always_comb begin
      num_n  = 2'd0;
      num_b0 = pdfte_pkg::CH_TAB;
      num_b1 = pdfte_pkg::CH_LF;
      if (!kind_open_ff) begin
         priority if (digs_ff && ((acc_ff > pdfte_pkg::NUM_ONE) ||
                                  ((acc_ff == pdfte_pkg::NUM_ONE) && frac_ff))) begin
            num_n  = 2'd2;
            num_b0 = pdfte_pkg::CH_CR;
         end else if (!digs_ff || (acc_ff == '0)) begin
            num_n = 2'd1;
         end else begin
            num_n = 2'd0;
         end
      end else begin
         priority if (digs_ff && (acc_ff > pdfte_pkg::NUM_TAB_MIN)) begin
            num_n = 2'd1;
         end else if (digs_ff && (acc_ff > pdfte_pkg::NUM_SP_MIN)) begin
            num_n  = 2'd1;
            num_b0 = pdfte_pkg::CH_SP;
         end else begin
            num_n = 2'd0;
         end
      end
   end

   // end-of-byte flag update and text beats
   assign printable = ((char_ff >= pdfte_pkg::CH_SP) && (char_ff <= pdfte_pkg::CH_TILDE)) ||
                      ((char_ff >= pdfte_pkg::CH_HI) && (char_ff != pdfte_pkg::CH_FF));

   always_comb begin
      fin_n    = 2'd0;
      fin_b0   = char_ff;
      fin_b1   = pdfte_pkg::CH_LF;
      tobj_mid = tobj_ff;
      str_in   = str_ff;
      esc_in   = esc_ff;
      if (tobj_ff) begin
         priority if (et_hit) begin
            tobj_mid = 1'b0;
            fin_n    = 2'd2;
            fin_b0   = pdfte_pkg::CH_CR;
         end else if (open_hit) begin
            str_in = 1'b1;
         end else if ((char_ff == pdfte_pkg::CH_RPAR) && str_ff && !esc_ff) begin
            str_in = 1'b0;
         end else if (str_ff) begin
            if ((char_ff == pdfte_pkg::CH_BSL) && !esc_ff) begin
               esc_in = 1'b1;
            end else begin
               esc_in = 1'b0;
               fin_n  = printable ? 2'd1 : 2'd0;
            end
         end else begin
            str_in = str_ff;
         end
      end
   end

   // beats queued this cycle
   always_comb begin
      push_n  = 2'd0;
      push_b0 = fin_b0;
      push_b1 = fin_b1;
      priority if (cmd.take_num) begin
         push_n  = num_n;
         push_b0 = num_b0;
         push_b1 = num_b1;
      end else if (cmd.finish) begin
         push_n = fin_n;
      end else begin
         push_n = 2'd0;
      end
   end

   assign cnt_in = cnt_ff + pdfte_pkg::CNT_W'(push_n);

   // status to controller
   always_comb begin
      stat            = '0;
      stat.td_hit     = td_hit;
      stat.open_hit   = open_hit;
      stat.at_zero    = (ptr_ff == '0);
      stat.cur_space  = (cur == pdfte_pkg::CH_SP);
      stat.cur_numch  = cur_digit || cur_dot;
      stat.parse_done = parse_done;
      stat.scan_is_td = !kind_open_ff;
      stat.will_emit  = (cnt_ff != '0) || (fin_n != 2'd0);
      stat.emit_last  = (pdfte_pkg::CNT_W'(idx_ff) + pdfte_pkg::CNT_W'(1)) == cnt_ff;
   end

   // result beat from buffer
   always_comb begin
      out_byte = buf_ff[0];
      for (int k = 0; k < pdfte_pkg::OUT_DEPTH; k++) begin
         if (idx_ff == pdfte_pkg::OIDX_W'(k)) begin
            out_byte = buf_ff[k];
         end
      end
   end
   assign out_last = stat.emit_last;

   // window and text flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pdfte_pkg::HIST_LEN; k++) begin
            hist_ff[k] <= pdfte_pkg::CH_SP;
         end
         tobj_ff <= 1'b0;
         str_ff  <= 1'b0;
         esc_ff  <= 1'b0;
      end else if (cmd.load && in_first) begin
         for (int k = 0; k < pdfte_pkg::HIST_LEN; k++) begin
            hist_ff[k] <= pdfte_pkg::CH_SP;
         end
         tobj_ff <= 1'b0;
         str_ff  <= 1'b0;
         esc_ff  <= 1'b0;
      end else if (cmd.finish) begin
         for (int k = 0; k < pdfte_pkg::HIST_LEN - 1; k++) begin
            hist_ff[k] <= hist_ff[k+1];
         end
         hist_ff[pdfte_pkg::HIST_LEN-1] <= char_ff;
         tobj_ff <= tobj_mid || bt_new;
         str_ff  <= str_in;
         esc_ff  <= esc_in;
      end
   end

   // current byte
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff <= in_byte;
      end
   end

   // number scanner
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         ptr_ff       <= cmd.scan_open ? pdfte_pkg::SLOT_OPEN : pdfte_pkg::SLOT_TD;
         last_ff      <= cmd.scan_open ? pdfte_pkg::SLOT_OPEN : pdfte_pkg::SLOT_TD;
         kind_open_ff <= cmd.scan_open;
      end else if (cmd.back_step) begin
         ptr_ff <= ptr_ff - pdfte_pkg::PTR_W'(1);
      end else if (cmd.parse_init) begin
         ptr_ff  <= ptr_ff + pdfte_pkg::PTR_W'(1);
         acc_ff  <= '0;
         dot_ff  <= 1'b0;
         frac_ff <= 1'b0;
         digs_ff <= 1'b0;
      end else if (cmd.parse_step) begin
         ptr_ff <= ptr_ff + pdfte_pkg::PTR_W'(1);
         if (cur_digit) begin
            digs_ff <= 1'b1;
            if (dot_ff) begin
               frac_ff <= frac_ff || (cur != pdfte_pkg::CH_ZERO);
            end else begin
               acc_ff <= acc_in;
            end
         end else begin
            dot_ff <= 1'b1;
         end
      end
   end

   // result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.emit_step) begin
            idx_ff <= idx_ff + pdfte_pkg::OIDX_W'(1);
         end
      end
   end

   // result buffer entries
   always_ff @(posedge clock) begin
      for (int k = 0; k < pdfte_pkg::OUT_DEPTH; k++) begin
         if ((push_n != 2'd0) && (cnt_ff == pdfte_pkg::CNT_W'(k))) begin
            buf_ff[k] <= push_b0;
         end else if ((push_n == 2'd2) &&
                      ((cnt_ff + pdfte_pkg::CNT_W'(1)) == pdfte_pkg::CNT_W'(k))) begin
            buf_ff[k] <= push_b1;
         end
      end
   end

   // a string only opens inside a text object, and ET is not seen in a string
   a_str_in_tobj: assert property (@(posedge clock) disable iff (reset)
      str_ff |-> tobj_ff)
      else $error("string flag set outside a text object");

   // an escape is only armed inside a string and cleared before it closes
   a_esc_in_str: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> str_ff)
      else $error("escape pending outside a string");

endmodule
